// ===== sv/tei_pkg.sv =====
// ----------------------------------------------------------------------------
// tei_pkg: shared definitions for the timed eased interpolator
// Default widths, register indexes, item codes, easing codes and the
// operation code of the iterative multiply/divide unit.
// ----------------------------------------------------------------------------
package tei_pkg;

  // Default widths of the block
  localparam int unsigned DEF_TIME_WIDTH    = 24;
  localparam int unsigned DEF_VALUE_WIDTH   = 32;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  // Default widths of the iterative unit: fraction operands carry one
  // integer bit, the accumulator covers the lerp magnitude and the
  // doubled division remainder.
  localparam int unsigned DEF_MUL_BITS = DEF_FRACTION_BITS + 1;
  localparam int unsigned DEF_ACC_TV   = (DEF_VALUE_WIDTH + 1 > DEF_TIME_WIDTH + 2) ?
                                         DEF_VALUE_WIDTH + 1 : DEF_TIME_WIDTH + 2;
  localparam int unsigned DEF_ACC_W    = (DEF_ACC_TV > DEF_MUL_BITS) ?
                                         DEF_ACC_TV : DEF_MUL_BITS;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_VALUE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EASE_MODE   = 2'd3;

  // Input item codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // Easing codes
  localparam int unsigned MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_LINEAR       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IN_CUBIC     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OUT_CUBIC    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_IN_OUT_CUBIC = 2'd3;

  // Iterative unit operations
  typedef enum logic {
    UOP_MUL,
    UOP_DIV
  } unit_op_e;

endpackage

// ===== sv/tei_iter_unit.sv =====
// ----------------------------------------------------------------------------
// tei_iter_unit: shared radix-2 multiply / restoring divide unit
// One adder, one bit per cycle. Multiply gives a_i * b_i in prod_o;
// divide takes a remainder below the divisor a_i and shifts NB-1 quotient
// bits into the low part of prod_o.
// ----------------------------------------------------------------------------
module tei_iter_unit #(
  parameter int unsigned AW = tei_pkg::DEF_ACC_W,
  parameter int unsigned NB = tei_pkg::DEF_MUL_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  tei_pkg::unit_op_e  op_i,
  input  logic [AW-1:0]      a_i,
  input  logic [AW-1:0]      acc_init_i,
  input  logic [NB-1:0]      b_i,
  output logic               done_o,
  output logic [AW+NB-1:0]   prod_o
);
  import tei_pkg::*;

  localparam int unsigned CW = $clog2(NB + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  unit_op_e      op_q, op_d;
  logic [AW-1:0] a_q, a_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [NB-1:0] mq_q, mq_d;

  logic [AW-1:0] add_x;
  logic [AW-1:0] add_y;
  logic          add_cin;
  logic [AW:0]   add_sum;

  // Shared adder: accumulate on multiply, trial subtract on divide
  always_comb begin
    if (op_q == UOP_DIV) begin
      add_x   = {acc_q[AW-2:0], 1'b0};
      add_y   = ~a_q;
      add_cin = 1'b1;
    end else begin
      add_x   = acc_q;
      add_y   = mq_q[0] ? a_q : '0;
      add_cin = 1'b0;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {{AW{1'b0}}, add_cin};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    a_d    = a_q;
    acc_d  = acc_q;
    mq_d   = mq_q;
    if (start_i) begin
      busy_d = 1'b1;
      op_d   = op_i;
      a_d    = a_i;
      acc_d  = acc_init_i;
      mq_d   = (op_i == UOP_DIV) ? '0 : b_i;
      cnt_d  = (op_i == UOP_DIV) ? CW'(NB - 1) : CW'(NB);
    end else if (busy_q) begin
      if (op_q == UOP_DIV) begin
        acc_d = add_sum[AW] ? add_sum[AW-1:0] : add_x;
        mq_d  = {mq_q[NB-2:0], add_sum[AW]};
      end else begin
        acc_d = add_sum[AW:1];
        mq_d  = {add_sum[0], mq_q[NB-1:1]};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    acc_q <= acc_d;
    mq_q  <= mq_d;
  end

  assign done_o = done_q;
  assign prod_o = {acc_q, mq_q};

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("tei_iter_unit: start while busy");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("tei_iter_unit: busy with no steps left");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("tei_iter_unit: done held for more than one cycle");

endmodule

// ===== sv/timed_eased_interpolator.sv =====
// ----------------------------------------------------------------------------
// timed_eased_interpolator: tween a value from start to end with easing
// Start and tick items in, one result per item out, iterative datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Write duration, endpoints and ease mode through the cfg port while idle.
//   The input channel (in_valid_i/in_ready_o) carries func_i and
//   delta_time_i; a start item latches the registers, a tick item advances
//   elapsed time. Every input transfer yields exactly one output transfer
//   (current_value_o, running_o) in order.
// Sequence:
//   Start items and inactive ticks go straight to the output step. An active
//   tick runs the shared multiply/divide unit: a divide (skipped when the
//   animation ends), two multiplies for cubic easing, and one for the lerp,
//   plus sequencer steps. All of these share the single adder of the
//   iterative unit, and the next item is taken only once the sequencer is
//   back in idle.
// Reset:
//   Registers return to duration 1, endpoints 0, linear; no animation runs
//   and the held value is 0.
// Stall:
//   The result register holds a finished result until the receiver takes
//   it; the next item is accepted meanwhile and waits for a free slot.
// ----------------------------------------------------------------------------
module timed_eased_interpolator #(
  parameter int unsigned TIME_WIDTH    = tei_pkg::DEF_TIME_WIDTH,
  parameter int unsigned VALUE_WIDTH   = tei_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned FRACTION_BITS = tei_pkg::DEF_FRACTION_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [tei_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [((TIME_WIDTH > VALUE_WIDTH) ? TIME_WIDTH : VALUE_WIDTH)-1:0]
                                               cfg_wdata_i,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [TIME_WIDTH-1:0]                delta_time_i,
  // result items
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [VALUE_WIDTH-1:0]        current_value_o,
  output logic                                 running_o
);
  import tei_pkg::*;

  localparam int unsigned T     = TIME_WIDTH;
  localparam int unsigned V     = VALUE_WIDTH;
  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned NB    = F + 1;
  localparam int unsigned AW_TV = (V + 1 > T + 2) ? V + 1 : T + 2;
  localparam int unsigned AW    = (AW_TV > NB) ? AW_TV : NB;
  localparam int unsigned PW    = AW + NB;

  localparam logic [NB-1:0] FRAC_ONE  = {1'b1, {F{1'b0}}};
  localparam logic [NB-1:0] FRAC_HALF = {2'b01, {(F-1){1'b0}}};
  localparam logic [PW:0]   RND_HALF  = (PW+1)'(FRAC_HALF);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;  // wait for an input transfer
  localparam logic [3:0] S_DIV  = 4'd1;  // t = elapsed / duration
  localparam logic [3:0] S_XSET = 4'd2;  // easing operand, launch x*x unless linear
  localparam logic [3:0] S_SQ   = 4'd3;  // x*x done, launch (x*x)*x
  localparam logic [3:0] S_CU   = 4'd4;  // cube done
  localparam logic [3:0] S_EFIN = 4'd5;  // eased t, launch lerp multiply
  localparam logic [3:0] S_LMUL = 4'd6;  // lerp product done, round
  localparam logic [3:0] S_LFIN = 4'd7;  // add to or subtract from start value
  localparam logic [3:0] S_OUT  = 4'd8;  // hand result to output register

  logic [3:0]            state_q, state_d;

  // configuration registers
  logic [T-1:0]          cfg_dur_q, cfg_dur_d;
  logic [V-1:0]          cfg_start_q, cfg_start_d;
  logic [V-1:0]          cfg_end_q, cfg_end_d;
  logic [MODE_W-1:0]     cfg_mode_q, cfg_mode_d;

  // animation state
  logic                  active_q, active_d;
  logic [T-1:0]          elapsed_q, elapsed_d;
  logic [V-1:0]          value_q, value_d;
  logic [T-1:0]          ldur_q;
  logic [V-1:0]          lstart_q;
  logic [MODE_W-1:0]     lmode_q;
  logic                  neg_q;
  logic [V:0]            mag_q;
  logic                  latch_start;

  // working registers
  logic [NB-1:0]         t_q, t_d;
  logic [NB-1:0]         x_q, x_d;
  logic [NB-1:0]         c_q, c_d;
  logic [V:0]            rnd_q, rnd_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [V-1:0]          out_data_q, out_data_d;
  logic                  out_run_q, out_run_d;

  // shared unit
  logic                  u_start;
  unit_op_e              u_op;
  logic [AW-1:0]         u_a;
  logic [AW-1:0]         u_acc;
  logic [NB-1:0]         u_b;
  logic                  u_done;
  logic [PW-1:0]         u_prod;

  // datapath helpers
  logic [T:0]            tick_sum;
  logic                  tick_end;
  logic [V:0]            diff_fwd;
  logic [V:0]            diff_rev;
  logic [PW:0]           prod_rnd;
  logic [AW+1:0]         rnd_all;
  logic [NB-1:0]         t_rev;
  logic [NB-1:0]         ease_val;

  tei_iter_unit #(
    .AW (AW),
    .NB (NB)
  ) u_iter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (u_start),
    .op_i       (u_op),
    .a_i        (u_a),
    .acc_init_i (u_acc),
    .b_i        (u_b),
    .done_o     (u_done),
    .prod_o     (u_prod)
  );

  // Register writes; an index beyond the list has no effect
  always_comb begin
    cfg_dur_d   = cfg_dur_q;
    cfg_start_d = cfg_start_q;
    cfg_end_d   = cfg_end_q;
    cfg_mode_d  = cfg_mode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DURATION:    cfg_dur_d   = cfg_wdata_i[T-1:0];
        REG_START_VALUE: cfg_start_d = cfg_wdata_i[V-1:0];
        REG_END_VALUE:   cfg_end_d   = cfg_wdata_i[V-1:0];
        REG_EASE_MODE:   cfg_mode_d  = cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Elapsed time advance; the end is reached once the sum meets the duration
  assign tick_sum = {1'b0, elapsed_q} + {1'b0, delta_time_i};
  assign tick_end = (tick_sum >= {1'b0, ldur_q});

  // Endpoint difference as sign and magnitude, both directions in parallel
  assign diff_fwd = {cfg_end_q[V-1], cfg_end_q} - {cfg_start_q[V-1], cfg_start_q};
  assign diff_rev = {cfg_start_q[V-1], cfg_start_q} - {cfg_end_q[V-1], cfg_end_q};

  // Round a product half up and drop the fraction bits
  assign prod_rnd = {1'b0, u_prod} + RND_HALF;
  assign rnd_all  = prod_rnd[PW:F];

  assign t_rev = FRAC_ONE - t_q;

  // Final eased fraction from the cube and t
  always_comb begin
    case (lmode_q)
      MODE_LINEAR:       ease_val = t_q;
      MODE_IN_CUBIC:     ease_val = c_q;
      MODE_OUT_CUBIC:    ease_val = FRAC_ONE - c_q;
      MODE_IN_OUT_CUBIC: ease_val = (t_q < FRAC_HALF) ? {c_q[NB-3:0], 2'b00}
                                                      : FRAC_ONE - {1'b0, c_q[NB-1:1]};
      default:           ease_val = t_q;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    elapsed_d   = elapsed_q;
    value_d     = value_q;
    latch_start = 1'b0;
    t_d         = t_q;
    x_d         = x_q;
    c_d         = c_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_run_d   = out_run_q;
    u_start     = 1'b0;
    u_op        = UOP_MUL;
    u_a         = '0;
    u_acc       = '0;
    u_b         = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_START) begin
            // restart from the remaining time of a running animation
            elapsed_d   = active_q ? ldur_q - elapsed_q : '0;
            active_d    = 1'b1;
            latch_start = 1'b1;
            state_d     = S_OUT;
          end else if (active_q) begin
            if (tick_end) begin
              // clamp at the duration; also covers a zero duration
              active_d  = 1'b0;
              elapsed_d = ldur_q;
              t_d       = FRAC_ONE;
              state_d   = S_XSET;
            end else begin
              elapsed_d = tick_sum[T-1:0];
              u_start   = 1'b1;
              u_op      = UOP_DIV;
              u_a       = AW'(ldur_q);
              u_acc     = AW'(tick_sum[T-1:0]);
              state_d   = S_DIV;
            end
          end else begin
            // inactive tick: hold the value
            state_d = S_OUT;
          end
        end
      end

      S_DIV: begin
        if (u_done) begin
          t_d     = u_prod[NB-1:0];
          state_d = S_XSET;
        end
      end

      S_XSET: begin
        case (lmode_q)
          MODE_IN_CUBIC:     x_d = t_q;
          MODE_OUT_CUBIC:    x_d = t_rev;
          MODE_IN_OUT_CUBIC: x_d = (t_q < FRAC_HALF) ? t_q : {t_rev[NB-2:0], 1'b0};
          default:           x_d = x_q;
        endcase
        if (lmode_q == MODE_LINEAR) begin
          state_d = S_EFIN;
        end else begin
          u_start = 1'b1;
          u_op    = UOP_MUL;
          u_a     = AW'(x_d);
          u_b     = x_d;
          state_d = S_SQ;
        end
      end

      S_SQ: begin
        if (u_done) begin
          u_start = 1'b1;
          u_op    = UOP_MUL;
          u_a     = AW'(rnd_all[NB-1:0]);
          u_b     = x_q;
          state_d = S_CU;
        end
      end

      S_CU: begin
        if (u_done) begin
          c_d     = rnd_all[NB-1:0];
          state_d = S_EFIN;
        end
      end

      S_EFIN: begin
        u_start = 1'b1;
        u_op    = UOP_MUL;
        u_a     = AW'(mag_q);
        u_b     = ease_val;
        state_d = S_LMUL;
      end

      S_LMUL: begin
        if (u_done) begin
          rnd_d   = rnd_all[V:0];
          state_d = S_LFIN;
        end
      end

      S_LFIN: begin
        value_d = neg_q ? lstart_q - rnd_q[V-1:0] : lstart_q + rnd_q[V-1:0];
        state_d = S_OUT;
      end

      S_OUT: begin
        // wait for a free output slot
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = value_q;
          out_run_d   = active_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_dur_q   <= T'(1);
      cfg_start_q <= '0;
      cfg_end_q   <= '0;
      cfg_mode_q  <= MODE_LINEAR;
      active_q    <= 1'b0;
      elapsed_q   <= '0;
      value_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_dur_q   <= cfg_dur_d;
      cfg_start_q <= cfg_start_d;
      cfg_end_q   <= cfg_end_d;
      cfg_mode_q  <= cfg_mode_d;
      active_q    <= active_d;
      elapsed_q   <= elapsed_d;
      value_q     <= value_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (latch_start) begin
      ldur_q   <= cfg_dur_q;
      lstart_q <= cfg_start_q;
      lmode_q  <= cfg_mode_q;
      neg_q    <= diff_fwd[V];
      mag_q    <= diff_fwd[V] ? diff_rev : diff_fwd;
    end
    t_q        <= t_d;
    x_q        <= x_d;
    c_q        <= c_d;
    rnd_q      <= rnd_d;
    out_data_q <= out_data_d;
    out_run_q  <= out_run_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign current_value_o = out_data_q;
  assign running_o       = out_run_q;

  a_end_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> (elapsed_q == ldur_q))
    else $error("timed_eased_interpolator: animation ended off the duration");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("timed_eased_interpolator: second item taken while busy");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XSET) |-> (t_q <= FRAC_ONE))
    else $error("timed_eased_interpolator: fraction above one");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> (state_q == S_DIV || state_q == S_SQ || state_q == S_CU ||
                state_q == S_LMUL))
    else $error("timed_eased_interpolator: unit result not awaited");

endmodule
